// ----- rtl/smsm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Square matrix self multiply: shared package
// Widths, reset values and the tag that travels with each operand pair
// through the multiply-accumulate pipeline.
// ----------------------------------------------------------------------------
package smsm_pkg;

   localparam int DEFAULT_MAX_DIM = 8;

   localparam int ELEM_W  = 16;
   localparam int PROD_W  = 2 * ELEM_W;
   localparam int ENTRY_W = 35;
   localparam int DIM_W   = 4;

   localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

   typedef struct packed {
      logic valid;
      logic first;
      logic last_term;
      logic last_entry;
   } smsm_tag_type;

endpackage

// ----- rtl/square_matrix_self_multiply.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Square matrix self multiply
// Loads an n x n matrix of signed Q8.8 elements in row-major order, then
// streams out the matrix squared as signed Q19.16 entries, row-major.
//
// Usage:
//   csr_write_en/csr_write_data set n (0 acts as 1, above MAX_DIM acts as
//   MAX_DIM) and restart loading. Write only while busy is low.
//   An element transaction is taken on a clock edge with start high and busy
//   low, one per cycle. The n*n-th element starts the computation and busy
//   rises; no element is taken until the last product entry has gone out.
//   Results appear one per strobe cycle on rsp_product_entry with
//   rsp_last_entry marking the final one; rsp_strobe lasts one cycle and the
//   receiver cannot stall it.
// Datapath:
//   One shared multiplier-accumulator does every term, one per cycle. Each
//   term passes the memory read registers, the product register and the
//   accumulator, whose sum goes out with the strobe. Memory reads are registered.
// Reset:
//   Synchronous, active high; n returns to 8 and loading restarts at the
//   first element. Matrix contents are not cleared.
// ----------------------------------------------------------------------------
module square_matrix_self_multiply
   import smsm_pkg::*;
#(
   parameter int MAX_DIM = DEFAULT_MAX_DIM
)
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic signed [ELEM_W-1:0]   req_element,
   output logic                       rsp_strobe,
   output logic signed [ENTRY_W-1:0]  rsp_product_entry,
   output logic                       rsp_last_entry,
   input  logic                       csr_write_en,
   input  logic [DIM_W-1:0]           csr_write_data
);

   localparam int CELLS = MAX_DIM * MAX_DIM;
   localparam int AW    = $clog2(CELLS);
   localparam int IW    = $clog2(MAX_DIM);

   localparam logic [1:0] ST_LOAD  = 2'd0;
   localparam logic [1:0] ST_CALC  = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;

   logic signed [ELEM_W-1:0] mem [CELLS];

   logic [DIM_W-1:0]  dim_ff;
   logic [DIM_W-1:0]  side;
   logic [IW-1:0]     side_m1;
   logic [AW-1:0]     side_a;
   logic [AW-1:0]     last_idx;
   logic [7:0]        total;

   logic [1:0]        state_ff, state_in;
   logic [AW-1:0]     count_ff, count_in;
   logic [IW-1:0]     i_ff, i_in;
   logic [IW-1:0]     j_ff, j_in;
   logic [IW-1:0]     t_ff, t_in;
   logic [AW-1:0]     row_ff, row_in;
   logic [AW-1:0]     a_addr_ff, a_addr_in;
   logic [AW-1:0]     b_addr_ff, b_addr_in;
   logic              mem_we;

   smsm_tag_type              issue_tag;
   smsm_tag_type              rd_tag_ff;
   logic signed [ELEM_W-1:0]  rd_a_ff;
   logic signed [ELEM_W-1:0]  rd_b_ff;

   always_comb begin
      if (dim_ff == '0) begin
         side = 4'd1;
      end else if ({1'b0, dim_ff} > 5'(MAX_DIM)) begin
         side = DIM_W'(MAX_DIM);
      end else begin
         side = dim_ff;
      end
   end

   assign side_m1  = IW'(side - 4'd1);
   assign side_a   = AW'(side);
   assign total    = {4'b0, side} * {4'b0, side};
   assign last_idx = AW'(total - 8'd1);

   assign issue_tag.valid      = (state_ff == ST_CALC);
   assign issue_tag.first      = (t_ff == '0);
   assign issue_tag.last_term  = (t_ff == side_m1);
   assign issue_tag.last_entry = (t_ff == side_m1) && (i_ff == side_m1) && (j_ff == side_m1);

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      t_in      = t_ff;
      row_in    = row_ff;
      a_addr_in = a_addr_ff;
      b_addr_in = b_addr_ff;
      mem_we    = 1'b0;
      if (csr_write_en) begin
         count_in = '0;
      end
      case (state_ff)
         ST_LOAD: begin
            if (start) begin
               mem_we = 1'b1;
               if (count_ff == last_idx) begin
                  count_in  = '0;
                  state_in  = ST_CALC;
                  i_in      = '0;
                  j_in      = '0;
                  t_in      = '0;
                  row_in    = '0;
                  a_addr_in = '0;
                  b_addr_in = '0;
               end else begin
                  count_in = count_ff + 1'b1;
               end
            end
         end
         ST_CALC: begin
            if (!issue_tag.last_term) begin
               t_in      = t_ff + 1'b1;
               a_addr_in = a_addr_ff + 1'b1;
               b_addr_in = b_addr_ff + side_a;
            end else begin
               t_in = '0;
               if (issue_tag.last_entry) begin
                  state_in = ST_DRAIN;
               end else if (j_ff != side_m1) begin
                  j_in      = j_ff + 1'b1;
                  a_addr_in = row_ff;
                  b_addr_in = AW'(j_ff) + 1'b1;
               end else begin
                  j_in      = '0;
                  i_in      = i_ff + 1'b1;
                  row_in    = row_ff + side_a;
                  a_addr_in = row_ff + side_a;
                  b_addr_in = '0;
               end
            end
         end
         ST_DRAIN: begin
            if (rsp_strobe && rsp_last_entry) begin
               state_in = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dim_ff    <= DIM_RESET;
         state_ff  <= ST_LOAD;
         count_ff  <= '0;
         i_ff      <= '0;
         j_ff      <= '0;
         t_ff      <= '0;
         row_ff    <= '0;
         a_addr_ff <= '0;
         b_addr_ff <= '0;
         rd_tag_ff <= '0;
      end else begin
         if (csr_write_en) begin
            dim_ff <= csr_write_data;
         end
         state_ff  <= state_in;
         count_ff  <= count_in;
         i_ff      <= i_in;
         j_ff      <= j_in;
         t_ff      <= t_in;
         row_ff    <= row_in;
         a_addr_ff <= a_addr_in;
         b_addr_ff <= b_addr_in;
         rd_tag_ff <= issue_tag;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[count_ff] <= req_element;
      end
   end

   always_ff @(posedge clock) begin
      rd_a_ff <= mem[a_addr_ff];
      rd_b_ff <= mem[b_addr_ff];
   end

   smsm_mac u_mac (
      .clock      (clock),
      .reset      (reset),
      .op_a       (rd_a_ff),
      .op_b       (rd_b_ff),
      .op_tag     (rd_tag_ff),
      .res_strobe (rsp_strobe),
      .res_entry  (rsp_product_entry),
      .res_last   (rsp_last_entry)
   );

   assign busy = (state_ff != ST_LOAD);

   a_no_result_when_idle: assert property (
      @(posedge clock) disable iff (reset) !busy |-> !rsp_strobe
   ) else $error("result strobe while idle");

   a_last_releases: assert property (
      @(posedge clock) disable iff (reset) (rsp_strobe && rsp_last_entry) |=> !busy
   ) else $error("busy held after final entry");

   a_release_after_last: assert property (
      @(posedge clock) disable iff (reset) $fell(busy) |-> $past(rsp_strobe && rsp_last_entry)
   ) else $error("busy dropped before final entry");

   a_last_is_strobed: assert property (
      @(posedge clock) disable iff (reset) rsp_last_entry |-> rsp_strobe
   ) else $error("last marker without strobe");

endmodule

// ----- rtl/smsm_mac.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Square matrix self multiply: multiply-accumulate unit
// Registers one signed product per cycle and folds it into a running sum
// that restarts on the first term of each entry; emits the sum on the last.
// ----------------------------------------------------------------------------
module smsm_mac
   import smsm_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic signed [ELEM_W-1:0]   op_a,
   input  logic signed [ELEM_W-1:0]   op_b,
   input  smsm_tag_type               op_tag,
   output logic                       res_strobe,
   output logic signed [ENTRY_W-1:0]  res_entry,
   output logic                       res_last
);

   logic signed [PROD_W-1:0]  prod_ff;
   smsm_tag_type              prod_tag_ff;
   logic signed [ENTRY_W-1:0] acc_ff;
   logic signed [ENTRY_W-1:0] acc_in;
   logic signed [ENTRY_W-1:0] prod_ext;
   logic                      strobe_ff;
   logic                      last_ff;

   assign prod_ext = {{(ENTRY_W - PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
   assign acc_in   = (prod_tag_ff.first ? '0 : acc_ff) + prod_ext;

   always_ff @(posedge clock) begin
      prod_ff <= op_a * op_b;
      if (prod_tag_ff.valid) begin
         acc_ff <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_tag_ff <= '0;
         strobe_ff   <= 1'b0;
         last_ff     <= 1'b0;
      end else begin
         prod_tag_ff <= op_tag;
         strobe_ff   <= prod_tag_ff.valid & prod_tag_ff.last_term;
         last_ff     <= prod_tag_ff.valid & prod_tag_ff.last_entry;
      end
   end

   assign res_strobe = strobe_ff;
   assign res_entry  = acc_ff;
   assign res_last   = last_ff;

endmodule
